[sv/rbd_pkg.sv]
package rbd_pkg;

  // command codes carried in s_tuser
  localparam int CMD_W = 3;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_CLEAR      = 3'd4;

  // fixed field widths of the stream payloads
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 5;
  localparam int CAP_W     = 5;
  localparam int OUT_TDATA_W = 48;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CAP_W-1:0]   cap_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;      // input transfer taken, run the command
    logic load_out;  // move the finished result into the output register
  } rbd_ctrl_t;

endpackage

[sv/ring_buffer_deque.sv]
// double-ended queue in a ring store of up to DEPTH entries of WIDTH bits
// input channel s_*: one command per transfer, s_tuser selects push front,
//   push back, pop front, pop back or clear, s_tdata carries the item to push
// output channel m_*: one result per input transfer, in order; m_tuser is
//   the success flag, m_tdata holds the popped item and the used and free
//   counts after the command
// cfg_we/cfg_data write the capacity; 0 acts as 1, above DEPTH acts as DEPTH,
//   and every write empties the queue (store contents are kept)
// result path: the command's result is registered along with the read of the
//   store, then moved into the output register, where it is presented
// throughput: one transfer per cycle while the receiver keeps up, as the
//   result stage frees itself in the same cycle the next command enters
// stall: a result held by a low m_tready keeps the one command already
//   taken waiting in its stage, and s_tready stays low until the output
//   register can take it
// reset: empty queue, both indices at slot 0, capacity 16 (or DEPTH if
//   smaller), no result pending; the store itself is not cleared
module ring_buffer_deque #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  rbd_pkg::data_t                   s_tdata,   // write_data
  input  rbd_pkg::cmd_t                    s_tuser,   // command
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // read_data [31:0], used_count [36:32], free_count [41:37], zero fill
  output logic [rbd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [0:0]                       m_tuser,   // ok
  input  logic                             cfg_we,
  input  rbd_pkg::cap_t                    cfg_data   // capacity
);
  import rbd_pkg::*;

  // largest sum of used and free counts the capacity register allows
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

  rbd_ctrl_t ctrl;
  logic      ok;
  data_t     read_data;
  count_t    used_count;
  count_t    free_count;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  rbd_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .command    (s_tuser),
    .write_data (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .ok         (ok),
    .read_data  (read_data),
    .used_count (used_count),
    .free_count (free_count)
  );

  // pack the result fields, lowest first
  assign m_tdata = {(OUT_TDATA_W - DATA_W - 2 * COUNT_W)'(0), free_count, used_count, read_data};
  assign m_tuser = ok;

  // a failed command never returns data
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0))
    else $error("failed command returned data");

  // used plus free never exceeds the largest capacity
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (({1'b0, m_tdata[36:32]} + {1'b0, m_tdata[41:37]}) <= 6'(CAP_MAX)))
    else $error("used and free counts exceed capacity");

  // a clear transfer reports an empty queue
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == CMD_CLEAR)) |=> ##1
      (!m_tvalid || !m_tuser[0] || (m_tdata[36:32] == '0) || $past(!m_tready)))
    else $error("clear left entries in the queue");

  // nothing is presented straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

[sv/rbd_ctrl.sv]
module rbd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output rbd_pkg::rbd_ctrl_t ctrl
);
  import rbd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DONE = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign out_free      = !m_tvalid || m_tready;
  assign ctrl.load_out = (state == ST_DONE) && out_free;
  assign s_tready      = (state == ST_IDLE) || ctrl.load_out;
  assign ctrl.exec     = s_tvalid && s_tready;

  always_comb begin
    priority if (ctrl.exec) begin
      state_next = ST_DONE;
    end else if (ctrl.load_out) begin
      state_next = ST_IDLE;
    end else begin
      state_next = state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[sv/rbd_datapath.sv]
module rbd_datapath #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  rbd_pkg::rbd_ctrl_t ctrl,
  input  rbd_pkg::cmd_t      command,
  input  rbd_pkg::data_t     write_data,
  input  logic               cfg_we,
  input  rbd_pkg::cap_t      cfg_data,
  output logic               ok,
  output rbd_pkg::data_t     read_data,
  output rbd_pkg::count_t    used_count,
  output rbd_pkg::count_t    free_count
);
  import rbd_pkg::*;

  localparam int PW      = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

  typedef logic [PW-1:0]    ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] mem_q;

  ptr_t head, head_next;
  ptr_t tail, tail_next;
  cnt_t held, held_next;
  cnt_t cap_eff;

  ptr_t addr;
  logic mem_we;
  logic mem_re;
  logic ok_next;
  logic pop_next;

  logic   ok_q;
  logic   pop_q;
  count_t used_q;
  count_t free_q;

  function automatic ptr_t step_back(ptr_t idx, cnt_t cap);
    step_back = (idx == '0) ? PW'(cap - cnt_t'(1)) : idx - ptr_t'(1);
  endfunction

  function automatic ptr_t step_fwd(ptr_t idx, cnt_t cap);
    step_fwd = ((CNT_W'(idx) + cnt_t'(1)) >= cap) ? '0 : idx + ptr_t'(1);
  endfunction

  always_comb begin
    head_next = head;
    tail_next = tail;
    held_next = held;
    addr      = head;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    ok_next   = 1'b0;
    pop_next  = 1'b0;
    if (ctrl.exec) begin
      unique case (command)
        CMD_PUSH_FRONT: begin
          if (held < cap_eff) begin
            head_next = step_back(head, cap_eff);
            addr      = head_next;
            mem_we    = 1'b1;
            held_next = held + cnt_t'(1);
            ok_next   = 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (held < cap_eff) begin
            addr      = tail;
            mem_we    = 1'b1;
            tail_next = step_fwd(tail, cap_eff);
            held_next = held + cnt_t'(1);
            ok_next   = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (held != '0) begin
            addr      = head;
            mem_re    = 1'b1;
            head_next = step_fwd(head, cap_eff);
            held_next = held - cnt_t'(1);
            ok_next   = 1'b1;
            pop_next  = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (held != '0) begin
            tail_next = step_back(tail, cap_eff);
            addr      = tail_next;
            mem_re    = 1'b1;
            held_next = held - cnt_t'(1);
            ok_next   = 1'b1;
            pop_next  = 1'b1;
          end
        end
        CMD_CLEAR: begin
          head_next = '0;
          tail_next = '0;
          held_next = '0;
          ok_next   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // ring store, one access a cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= WIDTH'(write_data);
    end
    if (mem_re) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      held    <= '0;
      cap_eff <= CNT_W'(CAP_RST);
    end else if (cfg_we) begin
      head <= '0;
      tail <= '0;
      held <= '0;
      if (cfg_data == '0) begin
        cap_eff <= cnt_t'(1);
      end else if (32'(cfg_data) > 32'(DEPTH)) begin
        cap_eff <= CNT_W'(DEPTH);
      end else begin
        cap_eff <= CNT_W'(cfg_data);
      end
    end else begin
      head <= head_next;
      tail <= tail_next;
      held <= held_next;
    end
  end

  // result held while the read completes
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      ok_q   <= ok_next;
      pop_q  <= pop_next;
      used_q <= COUNT_W'(held_next);
      free_q <= COUNT_W'(cap_eff - held_next);
    end
    if (ctrl.load_out) begin
      ok         <= ok_q;
      read_data  <= pop_q ? DATA_W'(mem_q) : '0;
      used_count <= used_q;
      free_count <= free_q;
    end
  end

endmodule

[dv/tb_ring_buffer_deque.sv]
module tb_ring_buffer_deque;
  import rbd_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int LIMIT_CYCLES = 200000;
  // cycles the receiver refuses results during the back-pressure phase
  localparam int HOLD_CYCLES  = 100;
  localparam int RING_DEPTH   = 16;
  localparam int SLOT_W       = $clog2(RING_DEPTH);

  // command codes the block leaves unused
  localparam cmd_t CMD_SPARE_FIRST = CMD_CLEAR + cmd_t'(1);
  localparam cmd_t CMD_SPARE_LAST  = '1;
  // largest value the capacity register can hold
  localparam cap_t CAP_TOP = '1;

  // one result transfer as the block should present it
  typedef struct {
    logic   ok;
    data_t  read_data;
    count_t used_count;
    count_t free_count;
  } deque_result_t;

  // shadow of the deque plus the results still owed by the block
  class deque_scoreboard;
    data_t         slots [RING_DEPTH];
    int            head;
    int            tail;
    int            held;
    cap_t          capacity;
    deque_result_t awaited [$];
    int            fail_count;

    function new();
      capacity   = cap_t'(RING_DEPTH);
      head       = 0;
      tail       = 0;
      held       = 0;
      fail_count = 0;
    endfunction

    // a capacity write also empties the queue, slots keep their contents
    function void load_capacity(cap_t value);
      capacity = value;
      head     = 0;
      tail     = 0;
      held     = 0;
    endfunction

    // capacity as the ring actually uses it, saturated to 1..depth
    function int ring_span();
      if (capacity == 0) return 1;
      if (capacity > RING_DEPTH) return RING_DEPTH;
      return int'(capacity);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_command(cmd_t cmd, data_t data);
      deque_result_t res;
      int            span;
      span = ring_span();
      if (head >= span) head = 0;
      if (tail >= span) tail = 0;
      if (held > span) held = span;
      res.ok        = 1'b0;
      res.read_data = '0;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (held < span) begin
            head                    = (head == 0) ? span - 1 : head - 1;
            slots[head[SLOT_W-1:0]] = data;
            held++;
            res.ok = 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (held < span) begin
            slots[tail[SLOT_W-1:0]] = data;
            tail                    = (tail + 1 >= span) ? 0 : tail + 1;
            held++;
            res.ok = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (held != 0) begin
            res.read_data = slots[head[SLOT_W-1:0]];
            head          = (head + 1 >= span) ? 0 : head + 1;
            held--;
            res.ok = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (held != 0) begin
            tail          = (tail == 0) ? span - 1 : tail - 1;
            res.read_data = slots[tail[SLOT_W-1:0]];
            held--;
            res.ok = 1'b1;
          end
        end
        CMD_CLEAR: begin
          head   = 0;
          tail   = 0;
          held   = 0;
          res.ok = 1'b1;
        end
        default: begin
        end
      endcase
      res.used_count = count_t'(held);
      res.free_count = count_t'(span - held);
      awaited.push_back(res);
    endfunction

    function void check_result(logic [0:0] user, logic [OUT_TDATA_W-1:0] payload);
      deque_result_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
        return;
      end
      want = awaited.pop_front();
      if (user[0] !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, user[0]);
        fail_count++;
      end
      if (payload[DATA_W-1:0] !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, payload[DATA_W-1:0]);
        fail_count++;
      end
      if (payload[DATA_W+COUNT_W-1:DATA_W] !== want.used_count) begin
        $error("used_count: expected %0d, got %0d", want.used_count,
               payload[DATA_W+COUNT_W-1:DATA_W]);
        fail_count++;
      end
      if (payload[DATA_W+2*COUNT_W-1:DATA_W+COUNT_W] !== want.free_count) begin
        $error("free_count: expected %0d, got %0d", want.free_count,
               payload[DATA_W+2*COUNT_W-1:DATA_W+COUNT_W]);
        fail_count++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  data_t                  s_tdata = '0;
  cmd_t                   s_tuser = CMD_CLEAR;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   cfg_we = 1'b0;
  cap_t                   cfg_data = '0;

  // idling odds in percent, changed per phase by the stimulus
  int send_idle  = 0;
  int recv_stall = 0;
  // remaining cycles of forced receiver hold-off
  int hold_left  = 0;
  int cycle_count = 0;

  deque_scoreboard sb = new();

  ring_buffer_deque dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off while hold_left runs down
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor: note each command transfer first, so a result in the same edge
  // always finds its expectation queued
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_command(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end
  end

  // watchdog on the whole run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one command, after a random idle gap, and hold it until the transfer;
  // the caller drives s_tvalid again in the step this returns
  task automatic send_command(cmd_t cmd, data_t data);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // margin after the last result
    repeat (3) @(posedge clk);
  endtask

  // capacity write, only ever with the block idle
  task automatic write_capacity(cap_t value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_capacity(value);
  endtask

  // mostly pushes and pops steered by push_pct, with some clears and spare codes
  task automatic send_random(int push_pct);
    int   roll;
    cmd_t cmd;
    roll = $urandom_range(99);
    if (roll < 4) cmd = CMD_CLEAR;
    else if (roll < 6) cmd = cmd_t'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    else if ($urandom_range(99) < push_pct)
      cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    else
      cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    send_command(cmd, $urandom());
  endtask

  // bursts that fill, drain or churn the queue so full and empty both recur
  task automatic run_random(int count);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      send_random(push_pct);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset capacity of 16, pops on empty, data extremes, spare codes
    send_command(CMD_POP_FRONT, 32'h1234_5678);
    send_command(CMD_POP_BACK, 32'h8765_4321);
    send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_FRONT, 32'h0000_0000);
    send_command(CMD_PUSH_BACK, 32'hA5A5_A5A5);
    send_command(CMD_POP_FRONT, 32'h5A5A_5A5A);
    send_command(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_FIRST, 32'hDEAD_BEEF);
    send_command(CMD_SPARE_LAST, 32'hCAFE_F00D);
    send_command(CMD_CLEAR, 32'hFFFF_FFFF);
    send_command(CMD_POP_FRONT, 32'h0);

    // capacity zero acts as a single slot: second push must fail
    write_capacity('0);
    send_command(CMD_PUSH_FRONT, 32'h5555_AAAA);
    send_command(CMD_PUSH_BACK, 32'hAAAA_5555);
    send_command(CMD_PUSH_FRONT, 32'h0F0F_0F0F);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_SPARE_FIRST + cmd_t'(1), 32'h0);

    // small ring: front pushes wrap the head below slot 0
    write_capacity(cap_t'(3));
    send_command(CMD_PUSH_FRONT, 32'h0000_0011);
    send_command(CMD_PUSH_FRONT, 32'h0000_0022);
    send_command(CMD_PUSH_BACK, 32'h0000_0033);
    send_command(CMD_PUSH_BACK, 32'h0000_0044);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);

    // no idling, capacity above depth saturates
    write_capacity(CAP_TOP);
    run_random(75);

    // sender mostly idle, single-slot ring
    send_idle  = 72;
    recv_stall = 0;
    write_capacity(cap_t'(1));
    run_random(75);

    // receiver mostly stalling, random mid-range capacity
    send_idle  = 0;
    recv_stall = 72;
    write_capacity(cap_t'($urandom_range(RING_DEPTH - 1, 2)));
    run_random(75);

    // both sides idling, full depth
    send_idle  = 25;
    recv_stall = 25;
    write_capacity(cap_t'(RING_DEPTH));
    run_random(75);

    // back-pressure: receiver holds off while the sender keeps offering
    send_idle  = 0;
    recv_stall = 0;
    drain();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_random(85);
    send_idle  = 25;
    recv_stall = 25;
    run_random(40);

    drain();
    if (sb.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[ring_buffer_deque.f]
sv/rbd_pkg.sv
sv/rbd_ctrl.sv
sv/rbd_datapath.sv
sv/ring_buffer_deque.sv
dv/tb_ring_buffer_deque.sv
